// ===== hdl/fts_pkg.sv =====
package fts_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;
    localparam int BURST_BITS_DEF  = 16;

    localparam int STATUS_BITS = 2;
    localparam int WAIT_BITS   = 32;
    localparam int TIME_BITS   = 32;

    localparam logic CMD_ARRIVE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [STATUS_BITS-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_ZERO = 2'd2;

    // per-cell control
    typedef struct packed {
        logic load;
        logic shift;
        logic dec;
    } fts_cell_ctrl_t;

    // queue control from the scheduler
    typedef struct packed {
        logic push;
        logic pop;
        logic dec;
    } fts_q_ctrl_t;

endpackage

// ===== hdl/fts_cell.sv =====
module fts_cell #(
    parameter int ID_BITS    = fts_pkg::ID_BITS_DEF,
    parameter int BURST_BITS = fts_pkg::BURST_BITS_DEF
) (
    input  logic                   aclk,
    input  fts_pkg::fts_cell_ctrl_t ctrl,
    input  logic [ID_BITS-1:0]     load_id,
    input  logic [BURST_BITS-1:0]  load_rem,
    input  logic [ID_BITS-1:0]     next_id,
    input  logic [BURST_BITS-1:0]  next_rem,
    output logic [ID_BITS-1:0]     id,
    output logic [BURST_BITS-1:0]  rem
);

    logic [ID_BITS-1:0]    id_reg, id_next;
    logic [BURST_BITS-1:0] rem_reg, rem_next;

    always_comb begin
        id_next  = id_reg;
        rem_next = rem_reg;
        priority if (ctrl.load) begin
            id_next  = load_id;
            rem_next = load_rem;
        end else if (ctrl.shift) begin
            id_next  = next_id;
            rem_next = next_rem;
        end else if (ctrl.dec) begin
            rem_next = rem_reg - BURST_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        id_reg  <= id_next;
        rem_reg <= rem_next;
    end

    assign id  = id_reg;
    assign rem = rem_reg;

endmodule

// ===== hdl/fts_queue.sv =====
module fts_queue #(
    parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = fts_pkg::ID_BITS_DEF,
    parameter int BURST_BITS  = fts_pkg::BURST_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  fts_pkg::fts_q_ctrl_t               ctrl,
    input  logic [ID_BITS-1:0]                 push_id,
    input  logic [BURST_BITS-1:0]              push_rem,
    output logic [ID_BITS-1:0]                 head_id,
    output logic [BURST_BITS-1:0]              head_rem,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0] count_reg, count_next;

    logic [ID_BITS-1:0]    cell_id  [QUEUE_DEPTH];
    logic [BURST_BITS-1:0] cell_rem [QUEUE_DEPTH];

    // head sits in cell 0, a pop shifts every cell one place towards it
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        fts_pkg::fts_cell_ctrl_t cc;
        logic [ID_BITS-1:0]      nb_id;
        logic [BURST_BITS-1:0]   nb_rem;

        assign cc.load  = ctrl.push && (count_reg == CNT_W'(i));
        assign cc.shift = ctrl.pop;
        assign cc.dec   = ctrl.dec && (i == 0);

        if (i == QUEUE_DEPTH - 1) begin : g_last
            assign nb_id  = cell_id[i];
            assign nb_rem = cell_rem[i];
        end else begin : g_mid
            assign nb_id  = cell_id[i+1];
            assign nb_rem = cell_rem[i+1];
        end

        fts_cell #(
            .ID_BITS    (ID_BITS),
            .BURST_BITS (BURST_BITS)
        ) u_cell (
            .aclk     (aclk),
            .ctrl     (cc),
            .load_id  (push_id),
            .load_rem (push_rem),
            .next_id  (nb_id),
            .next_rem (nb_rem),
            .id       (cell_id[i]),
            .rem      (cell_rem[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        priority if (ctrl.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_id  = cell_id[0];
    assign head_rem = cell_rem[0];
    assign count    = count_reg;

endmodule

// ===== hdl/fcfs_tick_scheduler.sv =====
// First-come-first-served job scheduler without preemption. Each s_ transaction is an
// arrival (tuser = 0: job id and burst length queued at the tail, dropped with a status
// code when the burst is zero or the queue is full) or a tick (tuser = 1: the head job
// runs one unit and leaves the queue once its burst is used up). Every transaction gives
// exactly one m_ transaction carrying status, busy flag, running id, finished flag, the
// saturating total wait and the wrapping tick count. The queue is a row of cells with the
// head in the first cell and a shift towards it on completion, so one transaction per
// clock is sustained; each result goes through the output register and shows in the
// cycle after its input is taken, and s_tready drops only while that register is held.
module fcfs_tick_scheduler #(
    parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = fts_pkg::ID_BITS_DEF,
    parameter int BURST_BITS  = fts_pkg::BURST_BITS_DEF,
    localparam int IN_W       = ID_BITS + BURST_BITS,
    localparam int IN_BYTES   = 8 * ((IN_W + 7) / 8),
    localparam int OUT_W      = fts_pkg::STATUS_BITS + 2 + ID_BITS
                                + fts_pkg::WAIT_BITS + fts_pkg::TIME_BITS,
    localparam int OUT_BYTES  = 8 * ((OUT_W + 7) / 8)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_BYTES-1:0]  s_tdata,   // job_id, burst_length
    input  logic                 s_tuser,   // command
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_BYTES-1:0] m_tdata    // status, busy_res, running_id, finished,
                                            // total_wait, time_now
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int WB    = fts_pkg::WAIT_BITS;
    localparam int TB    = fts_pkg::TIME_BITS;

    logic [ID_BITS-1:0]    in_id;
    logic [BURST_BITS-1:0] in_burst;
    logic                  accept, is_tick;

    logic [ID_BITS-1:0]    head_id;
    logic [BURST_BITS-1:0] head_rem;
    logic [CNT_W-1:0]      count;
    logic                  has_job, done;

    fts_pkg::fts_q_ctrl_t  qc;

    logic [WB-1:0]  wait_reg, wait_next;
    logic [TB-1:0]  time_reg, time_next;
    logic [WB:0]    wait_sum;
    logic [1:0]     status;

    logic                 out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]     out_data_reg, out_data_next;

    assign in_id    = s_tdata[ID_BITS-1:0];
    assign in_burst = s_tdata[IN_W-1:ID_BITS];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_tick  = (s_tuser == fts_pkg::CMD_TICK);

    assign has_job = (count != '0);
    // head entries always hold a non-zero burst, so one unit left means done
    assign done    = has_job && (head_rem <= BURST_BITS'(1));

    always_comb begin
        status = fts_pkg::STAT_OK;
        if (!is_tick) begin
            priority if (in_burst == '0) begin
                status = fts_pkg::STAT_ZERO;
            end else if (count == CNT_W'(QUEUE_DEPTH)) begin
                status = fts_pkg::STAT_FULL;
            end
        end
    end

    assign qc.push = accept && !is_tick && (status == fts_pkg::STAT_OK);
    assign qc.pop  = accept && is_tick && done;
    assign qc.dec  = accept && is_tick && has_job && !done;

    fts_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .BURST_BITS  (BURST_BITS)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (qc),
        .push_id  (in_id),
        .push_rem (in_burst),
        .head_id  (head_id),
        .head_rem (head_rem),
        .count    (count)
    );

    // jobs behind the head add to the wait, saturating
    assign wait_sum = {1'b0, wait_reg} + (WB + 1)'(count) - (WB + 1)'(1);

    always_comb begin
        wait_next = wait_reg;
        time_next = time_reg;
        if (accept && is_tick) begin
            time_next = time_reg + TB'(1);
            if (has_job) begin
                wait_next = wait_sum[WB] ? {WB{1'b1}} : wait_sum[WB-1:0];
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_data_next  = {time_next, wait_next,
                              is_tick && done,
                              (is_tick && has_job) ? head_id : ID_BITS'(0),
                              is_tick && has_job,
                              status};
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wait_reg      <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            wait_reg      <= wait_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_BYTES'(out_data_reg);

endmodule

// ===== hdl/fts_checker.sv =====
module fts_checker #(
    parameter int ID_BITS     = fts_pkg::ID_BITS_DEF,
    parameter int OUT_BYTES   = 80
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [OUT_BYTES-1:0] m_tdata
);

    localparam int SB = fts_pkg::STATUS_BITS;

    logic [SB-1:0]      st;
    logic               busy, fin;
    logic [ID_BITS-1:0] rid;

    assign st   = m_tdata[SB-1:0];
    assign busy = m_tdata[SB];
    assign rid  = m_tdata[SB+ID_BITS:SB+1];
    assign fin  = m_tdata[SB+ID_BITS+1];

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == fts_pkg::STAT_OK) || (st == fts_pkg::STAT_FULL)
                     || (st == fts_pkg::STAT_ZERO))
        else $error("undefined status code");

    a_drop_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st != fts_pkg::STAT_OK) |-> !busy && !fin && (rid == '0))
        else $error("dropped arrival reports a running job");

    a_fin_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (fin || (rid != '0)) |-> busy)
        else $error("finished or running id without a running job");

endmodule

bind fcfs_tick_scheduler fts_checker #(
    .ID_BITS   (ID_BITS),
    .OUT_BYTES (OUT_BYTES)
) u_fts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/fcfs_tick_scheduler_checker.sv =====
`timescale 1ns / 1ps

module fcfs_tick_scheduler_checker #(
    parameter int QUEUE_DEPTH = fts_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = fts_pkg::ID_BITS_DEF,
    parameter int BURST_BITS  = fts_pkg::BURST_BITS_DEF,
    localparam int IN_W       = ID_BITS + BURST_BITS,
    localparam int IN_BYTES   = 8 * ((IN_W + 7) / 8),
    localparam int OUT_W      = fts_pkg::STATUS_BITS + 2 + ID_BITS + fts_pkg::WAIT_BITS
                                + fts_pkg::TIME_BITS,
    localparam int OUT_BYTES  = 8 * ((OUT_W + 7) / 8)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [IN_BYTES-1:0]  s_tdata,   // job_id, burst_length
    input  logic                 s_tuser,   // command
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [OUT_BYTES-1:0] m_tdata,   // status, busy_res, running_id, finished,
                                            // total_wait, time_now
    output int                   fail_count,
    output int                   pending
);

    localparam int STATUS_BITS = fts_pkg::STATUS_BITS;
    localparam int WAIT_BITS   = fts_pkg::WAIT_BITS;
    localparam int TIME_BITS   = fts_pkg::TIME_BITS;

    localparam int BUSY_POS = STATUS_BITS;
    localparam int ID_POS   = BUSY_POS + 1;
    localparam int DONE_POS = ID_POS + ID_BITS;
    localparam int WAIT_POS = DONE_POS + 1;
    localparam int TIME_POS = WAIT_POS + WAIT_BITS;

    localparam int RING_DEPTH = 16;

    typedef struct {
        logic [STATUS_BITS-1:0] status;
        logic                   busy;
        logic [ID_BITS-1:0]     run_id;
        logic                   finished;
        logic [WAIT_BITS-1:0]   wait_sum;
        logic [TIME_BITS-1:0]   ticks;
    } tick_report_t;

    // shadow of the job queue, head always at slot head_slot
    logic [ID_BITS-1:0]    job_id_slot   [QUEUE_DEPTH];
    logic [BURST_BITS-1:0] job_left_slot [QUEUE_DEPTH];
    int                    head_slot;
    int                    occupancy;
    logic [WAIT_BITS-1:0]  wait_sum;
    logic [TIME_BITS-1:0]  tick_total;

    // expected results in order, oldest at ring_head
    tick_report_t awaited_reports [RING_DEPTH];
    int           ring_head  = 0;
    int           ring_count = 0;
    int           mismatches = 0;
    int           backlog    = 0;

    assign fail_count = mismatches;
    assign pending    = backlog;

    function automatic tick_report_t advance_scheduler(logic cmd, logic [ID_BITS-1:0] id,
                                                       logic [BURST_BITS-1:0] burst);
        tick_report_t         r;
        int                   tail;
        logic [WAIT_BITS:0]   sum;
        r.status   = fts_pkg::STAT_OK;
        r.busy     = 1'b0;
        r.run_id   = '0;
        r.finished = 1'b0;
        if (cmd == fts_pkg::CMD_ARRIVE) begin
            // zero burst wins over a full queue
            if (burst == '0) begin
                r.status = fts_pkg::STAT_ZERO;
            end else if (occupancy == QUEUE_DEPTH) begin
                r.status = fts_pkg::STAT_FULL;
            end else begin
                tail = (head_slot + occupancy) % QUEUE_DEPTH;
                job_id_slot[tail]   = id;
                job_left_slot[tail] = burst;
                occupancy++;
            end
        end else begin
            tick_total++;
            if (occupancy > 0) begin
                sum = {1'b0, wait_sum} + (WAIT_BITS + 1)'(occupancy - 1);
                wait_sum = sum[WAIT_BITS] ? '1 : sum[WAIT_BITS-1:0];
                r.busy   = 1'b1;
                r.run_id = job_id_slot[head_slot];
                job_left_slot[head_slot]--;
                if (job_left_slot[head_slot] == '0) begin
                    r.finished = 1'b1;
                    head_slot  = (head_slot + 1) % QUEUE_DEPTH;
                    occupancy--;
                end
            end
        end
        r.wait_sum = wait_sum;
        r.ticks    = tick_total;
        return r;
    endfunction

    task automatic compare_field(string field, logic [WAIT_BITS-1:0] want,
                                 logic [WAIT_BITS-1:0] got);
        if (got !== want) begin
            if (mismatches < 10)
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch
        tick_report_t want;
        tick_report_t fresh;
        if (!aresetn) begin
            head_slot  = 0;
            occupancy  = 0;
            wait_sum   = '0;
            tick_total = '0;
            ring_head  = 0;
            ring_count = 0;
        end else begin
            // retire first so a stray result is never paired with this edge's item
            if (m_tvalid && m_tready) begin
                if (ring_count == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result transaction %h", $realtime, m_tdata);
                    mismatches++;
                end else begin
                    want       = awaited_reports[ring_head];
                    ring_head  = (ring_head + 1) % RING_DEPTH;
                    ring_count--;
                    compare_field("status", want.status, m_tdata[STATUS_BITS-1:0]);
                    compare_field("busy_res", want.busy, m_tdata[BUSY_POS]);
                    compare_field("running_id", want.run_id, m_tdata[ID_POS +: ID_BITS]);
                    compare_field("finished", want.finished, m_tdata[DONE_POS]);
                    compare_field("total_wait", want.wait_sum, m_tdata[WAIT_POS +: WAIT_BITS]);
                    compare_field("time_now", want.ticks, m_tdata[TIME_POS +: TIME_BITS]);
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = advance_scheduler(s_tuser, s_tdata[ID_BITS-1:0],
                                          s_tdata[ID_BITS +: BURST_BITS]);
                if (ring_count == RING_DEPTH) begin
                    if (mismatches < 10)
                        $display("%0t: too many results outstanding", $realtime);
                    mismatches++;
                end else begin
                    awaited_reports[(ring_head + ring_count) % RING_DEPTH] = fresh;
                    ring_count++;
                end
            end
        end
        backlog = ring_count;
    end

endmodule

// ===== test/tb_fcfs_tick_scheduler.sv =====
`timescale 1ns / 1ps

module tb_fcfs_tick_scheduler;

    localparam int IN_W      = fts_pkg::ID_BITS_DEF + fts_pkg::BURST_BITS_DEF;
    localparam int IN_BYTES  = 8 * ((IN_W + 7) / 8);
    localparam int OUT_W     = fts_pkg::STATUS_BITS + 2 + fts_pkg::ID_BITS_DEF
                               + fts_pkg::WAIT_BITS + fts_pkg::TIME_BITS;
    localparam int OUT_BYTES = 8 * ((OUT_W + 7) / 8);
    localparam int RANDOM_ITEMS = 400;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_BYTES-1:0]  s_tdata;   // job_id, burst_length
    logic                 s_tuser;   // command
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_BYTES-1:0] m_tdata;   // status, busy_res, running_id, finished,
                                     // total_wait, time_now
    int                   fail_count;
    int                   pending;

    // when set, neither side inserts gaps or stalls
    logic                 steady;
    int                   items_sent;

    fcfs_tick_scheduler dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fcfs_tick_scheduler_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // called at a rising edge; returns at the edge where the transaction is taken
    task automatic send_item(logic cmd, logic [fts_pkg::ID_BITS_DEF-1:0] id,
                             logic [fts_pkg::BURST_BITS_DEF-1:0] burst);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(IN_BYTES - IN_W){1'b0}}, burst, id};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(fts_pkg::CMD_TICK, fts_pkg::ID_BITS_DEF'($urandom),
                  fts_pkg::BURST_BITS_DEF'($urandom));
    endtask

    task automatic send_job();
        logic [fts_pkg::BURST_BITS_DEF-1:0] burst;
        burst = ($urandom_range(0, 19) == 0) ? '0
                : fts_pkg::BURST_BITS_DEF'($urandom_range(1, 6));
        send_item(fts_pkg::CMD_ARRIVE, fts_pkg::ID_BITS_DEF'($urandom), burst);
    endtask

    // result side: random stall before each transaction
    initial begin : drain
        int stall;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin : stimulus
        int  arrivals;
        int  random_sent;
        bit  heavy;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tuser    <= fts_pkg::CMD_ARRIVE;
        s_tdata    <= '0;
        steady     = 1'b0;
        items_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle tick on an empty queue, then a zero-burst arrival
        send_item(fts_pkg::CMD_TICK, '0, '0);
        send_item(fts_pkg::CMD_ARRIVE, '0, '0);
        // fill the queue, the all-ones id included
        for (int i = 0; i < fts_pkg::QUEUE_DEPTH_DEF; i++)
            send_item(fts_pkg::CMD_ARRIVE, (i == 0) ? '1 : fts_pkg::ID_BITS_DEF'(i * 37),
                      fts_pkg::BURST_BITS_DEF'((i % 3) + 1));
        // full queue drop, and zero burst taking priority over full
        send_item(fts_pkg::CMD_ARRIVE, '1, '1);
        send_item(fts_pkg::CMD_ARRIVE, 8'h5a, '0);
        // ticks with junk in the ignored fields
        send_item(fts_pkg::CMD_TICK, '1, '1);
        repeat (4) send_tick();

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            // new traffic profile every forty transactions or so
            if (random_sent % 40 == 0) begin
                heavy  = $urandom_range(0, 1);
                steady = ($urandom_range(0, 3) == 0);
            end
            items_sent = 0;
            if ($urandom_range(0, 9) == 0) begin
                // noise: a run of back-to-back ticks or arrivals
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 1)) send_tick();
                    else send_job();
                end
            end else begin
                // one time unit: its arrivals, then its tick
                arrivals = heavy ? $urandom_range(0, 3) : ($urandom_range(0, 3) == 0);
                repeat (arrivals) send_job();
                send_tick();
            end
            random_sent += items_sent;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
